// File: rtl/core/npti_pkg.sv
// ----------------------------------------------------------------------------
// npti_pkg
// shared types and constants of the normal density trapezoid integrator
// ----------------------------------------------------------------------------
package npti_pkg;

    localparam int unsigned MAX_STEPS      = 1048576;
    localparam int unsigned PDF_TABLE_SIZE = 1024;
    localparam int unsigned IDX_W          = $clog2(PDF_TABLE_SIZE);
    localparam int unsigned STEP_CNT_W     = 25;
    localparam int unsigned H_W            = 24;
    localparam int unsigned PDF_W          = 24;
    localparam int unsigned ACC_W          = 49;

    localparam logic [H_W-1:0]   STEP_WIDTH_RESET = 24'd16777;
    localparam logic [ACC_W-1:0] AREA_ONE         = 49'h1_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] end_x;
    } in_item_t;

    typedef struct packed {
        logic [31:0] area;
        logic        steps_capped;
    } out_item_t;

    // one integration job handed from front to back
    typedef struct packed {
        logic signed [31:0]    lo;
        logic [H_W-1:0]        h;
        logic [STEP_CNT_W-1:0] n;
        logic                  capped;
    } job_t;

    // sample position within a job
    typedef struct packed {
        logic first;
        logic last;
    } tag_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_PUSH
    } front_state_t;

endpackage

// File: rtl/core/npti_front.sv
// ----------------------------------------------------------------------------
// npti_front
// accepts intervals, holds the step register, divides out the step count
// ----------------------------------------------------------------------------
module npti_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [23:0]              cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  npti_pkg::in_item_t       in_data,
    output logic                     job_valid,
    input  logic                     job_ready,
    output npti_pkg::job_t           job
);

    localparam logic [32:0] MAX_Q = 33'(npti_pkg::MAX_STEPS);

    npti_pkg::front_state_t state_reg, state_next;

    logic [npti_pkg::H_W-1:0] step_width_reg, step_width_next;
    logic signed [31:0]       lo_reg, lo_next;
    logic [npti_pkg::H_W-1:0] h_reg, h_next;
    logic [32:0]              quo_reg, quo_next;
    logic [24:0]              rem_reg, rem_next;
    logic [5:0]               cnt_reg, cnt_next;

    logic                     accept;
    logic                     div_done;
    logic signed [32:0]       diff;
    logic [24:0]              rem_sh;
    logic                     ge;
    logic                     capped;

    assign accept   = in_valid && in_ready;
    assign div_done = (cnt_reg == 6'd0);
    assign diff     = 33'(in_data.end_x) - 33'(in_data.start_x);
    assign rem_sh   = {rem_reg[23:0], quo_reg[32]};
    assign ge       = (rem_sh >= {1'b0, h_reg});
    assign capped   = (quo_reg > MAX_Q);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            npti_pkg::FS_IDLE:
            begin
                if (in_valid)
                    state_next = npti_pkg::FS_DIV;
            end
            npti_pkg::FS_DIV:
            begin
                if (div_done)
                    state_next = npti_pkg::FS_PUSH;
            end
            npti_pkg::FS_PUSH:
            begin
                if (job_ready)
                    state_next = npti_pkg::FS_IDLE;
            end
            default:
                state_next = npti_pkg::FS_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        job_valid = 1'b0;
        unique case (state_reg)
            npti_pkg::FS_IDLE: in_ready  = 1'b1;
            npti_pkg::FS_DIV:  in_ready  = 1'b0;
            npti_pkg::FS_PUSH: job_valid = 1'b1;
            default:           in_ready  = 1'b0;
        endcase
    end

    assign job.lo     = lo_reg;
    assign job.h      = h_reg;
    assign job.n      = capped ? npti_pkg::STEP_CNT_W'(npti_pkg::MAX_STEPS)
                               : quo_reg[npti_pkg::STEP_CNT_W-1:0];
    assign job.capped = capped;

    // datapath, one quotient bit a cycle
    always_comb
    begin
        step_width_next = cfg_we ? cfg_wdata : step_width_reg;
        lo_next  = lo_reg;
        h_next   = h_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            lo_next  = in_data.start_x;
            h_next   = (step_width_reg == '0) ? 24'd1 : step_width_reg;
            quo_next = (in_data.end_x > in_data.start_x) ? 33'(diff) : 33'd0;
            rem_next = '0;
            cnt_next = 6'd32;
        end
        else if (state_reg == npti_pkg::FS_DIV)
        begin
            rem_next = ge ? (rem_sh - {1'b0, h_reg}) : rem_sh;
            quo_next = {quo_reg[31:0], ge};
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= npti_pkg::FS_IDLE;
            step_width_reg <= npti_pkg::STEP_WIDTH_RESET;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            step_width_reg <= step_width_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        h_reg   <= h_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

endmodule

// File: rtl/core/npti_jobq.sv
// ----------------------------------------------------------------------------
// npti_jobq
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module npti_jobq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  npti_pkg::job_t wr_job,
    output logic           rd_valid,
    input  logic           rd_ready,
    output npti_pkg::job_t rd_job
);

    npti_pkg::job_t mem_reg [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_job   = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

// File: rtl/core/npti_density.sv
// ----------------------------------------------------------------------------
// npti_density
// four-stage interpolated normal density lookup, one sample a cycle
// ----------------------------------------------------------------------------
module npti_density (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_valid,
    input  logic signed [32:0]               s_x,
    input  npti_pkg::tag_t                   s_tag,
    output logic                             d_valid,
    output logic [npti_pkg::PDF_W-1:0]       d_pdf,
    output npti_pkg::tag_t                   d_tag
);

    localparam int unsigned SIZE  = npti_pkg::PDF_TABLE_SIZE;
    localparam int unsigned IW    = npti_pkg::IDX_W;
    localparam int unsigned PW    = 27 + IW;
    localparam logic [63:0] LN2_Q32      = 64'd2977044472;
    localparam logic [63:0] INV_SQRT2PI  = 64'd1713444047;
    localparam logic [63:0] ONE_Q32      = 64'd4294967296;
    localparam logic [63:0] SIZE_SQ      = 64'(SIZE) * 64'(SIZE);
    localparam logic [IW-1:0] LAST_IDX   = IW'(SIZE - 1);

    typedef logic [SIZE-1:0][npti_pkg::PDF_W-1:0] pdf_rom_t;

    function automatic logic [63:0] exp_neg_q32(input logic [63:0] u);
        logic [63:0] m;
        logic [63:0] r;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        m    = u / LN2_Q32;
        r    = u - m * LN2_Q32;
        term = ONE_Q32;
        pos  = ONE_Q32;
        neg  = '0;
        for (int i = 1; i <= 12; i++)
        begin
            term = ((term * r) >> 32) / 64'(i);
            if ((i % 2) == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        if (m >= 64'd40)
            return 64'd0;
        return (pos - neg) >> m;
    endfunction

    function automatic pdf_rom_t build_rom();
        pdf_rom_t    rom;
        logic [63:0] u;
        logic [63:0] e;
        logic [63:0] v;
        for (int k = 0; k < SIZE; k++)
        begin
            u = ((64'(k) * 64'(k)) << 37) / SIZE_SQ;
            e = exp_neg_q32(u);
            v = (e * INV_SQRT2PI + (64'd1 << 39)) >> 40;
            rom[k] = v[npti_pkg::PDF_W-1:0];
        end
        return rom;
    endfunction

    localparam pdf_rom_t PDF_ROM = build_rom();

    // stage 1: magnitude and table position
    logic [32:0]   a;
    logic [PW-1:0] p;

    logic          v1_reg;
    npti_pkg::tag_t tag1_reg;
    logic          far1_reg;
    logic [IW-1:0] idx1_reg;
    logic [26:0]   f1_reg;

    // stage 2: table read
    logic          v2_reg;
    npti_pkg::tag_t tag2_reg;
    logic          far2_reg;
    logic [26:0]   f2_reg;
    logic [23:0]   t0_reg;
    logic [23:0]   t1_reg;

    // stage 3: slope times fraction
    logic          up;
    logic [23:0]   diff;
    logic          v3_reg;
    npti_pkg::tag_t tag3_reg;
    logic          far3_reg;
    logic          up3_reg;
    logic [23:0]   t03_reg;
    logic [50:0]   prod3_reg;

    // stage 4: interpolate
    logic [23:0]   delta;
    logic [23:0]   pdf_next;
    logic          v4_reg;
    npti_pkg::tag_t tag4_reg;
    logic [23:0]   pdf4_reg;

    assign a     = s_x[32] ? 33'(-s_x) : 33'(s_x);
    assign p     = PW'(a[26:0]) * PW'(SIZE);
    assign up    = (t1_reg > t0_reg);
    assign diff  = up ? (t1_reg - t0_reg) : (t0_reg - t1_reg);
    assign delta = prod3_reg[50:27];
    assign pdf_next = far3_reg ? 24'd0 : (up3_reg ? (t03_reg + delta) : (t03_reg - delta));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tag1_reg  <= s_tag;
        far1_reg  <= (a[32:27] != 6'd0);
        idx1_reg  <= p[PW-1:27];
        f1_reg    <= p[26:0];

        tag2_reg  <= tag1_reg;
        far2_reg  <= far1_reg;
        f2_reg    <= f1_reg;
        t0_reg    <= PDF_ROM[idx1_reg];
        t1_reg    <= (idx1_reg == LAST_IDX) ? 24'd0 : PDF_ROM[idx1_reg + IW'(1)];

        tag3_reg  <= tag2_reg;
        far3_reg  <= far2_reg;
        up3_reg   <= up;
        t03_reg   <= t0_reg;
        prod3_reg <= 51'(diff) * 51'(f2_reg);

        tag4_reg  <= tag3_reg;
        pdf4_reg  <= pdf_next;
    end

    assign d_valid = v4_reg;
    assign d_pdf   = pdf4_reg;
    assign d_tag   = tag4_reg;

endmodule

// File: rtl/core/npti_back.sv
// ----------------------------------------------------------------------------
// npti_back
// walks the samples of one job, sums trapezoids, holds the result beat
// ----------------------------------------------------------------------------
module npti_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  npti_pkg::job_t      job,
    output logic                out_valid,
    input  logic                out_ready,
    output npti_pkg::out_item_t out_data
);

    localparam int unsigned CW = npti_pkg::STEP_CNT_W;

    logic busy_reg, busy_next;
    logic out_valid_reg, out_valid_next;
    npti_pkg::out_item_t out_data_reg, out_data_next;

    // sample generator
    logic                     gen_active_reg, gen_active_next;
    logic                     gen_first_reg, gen_first_next;
    logic signed [32:0]       gen_x_reg, gen_x_next;
    logic [CW-1:0]            gen_cnt_reg, gen_cnt_next;
    logic [CW-1:0]            gen_n_reg, gen_n_next;
    logic [npti_pkg::H_W-1:0] h_reg, h_next;
    logic                     capped_reg, capped_next;
    logic                     gen_last;
    npti_pkg::tag_t           gen_tag;

    // density stream
    logic                     d_valid;
    logic [23:0]              d_pdf;
    npti_pkg::tag_t           d_tag;

    // trapezoid stages
    logic [23:0]              fprev_reg;
    logic                     ts_valid_reg;
    logic                     ts_add_reg;
    logic                     ts_last_reg;
    logic [24:0]              ts_sum_reg;
    logic                     tm_valid_reg;
    logic                     tm_add_reg;
    logic                     tm_last_reg;
    logic [48:0]              tm_prod_reg;

    logic [npti_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [npti_pkg::ACC_W:0]   acc_sum;
    logic [npti_pkg::ACC_W-1:0] acc_upd;
    logic                       take;

    assign job_ready = !busy_reg && !out_valid_reg;
    assign take      = job_valid && job_ready;
    assign gen_last  = (gen_cnt_reg == gen_n_reg);
    assign gen_tag   = '{first: gen_first_reg, last: gen_last};

    npti_density u_density (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (gen_active_reg),
        .s_x     (gen_x_reg),
        .s_tag   (gen_tag),
        .d_valid (d_valid),
        .d_pdf   (d_pdf),
        .d_tag   (d_tag)
    );

    // saturating add, increments are never negative
    assign acc_sum = {1'b0, acc_reg} + 50'(tm_prod_reg >> 1);
    assign acc_upd = (acc_sum > 50'(npti_pkg::AREA_ONE)) ? npti_pkg::AREA_ONE
                                                         : acc_sum[npti_pkg::ACC_W-1:0];

    always_comb
    begin
        gen_active_next = gen_active_reg;
        gen_first_next  = gen_first_reg;
        gen_x_next      = gen_x_reg;
        gen_cnt_next    = gen_cnt_reg;
        gen_n_next      = gen_n_reg;
        h_next          = h_reg;
        capped_next     = capped_reg;
        busy_next       = busy_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (take)
        begin
            busy_next       = 1'b1;
            gen_active_next = 1'b1;
            gen_first_next  = 1'b1;
            gen_x_next      = 33'(job.lo);
            gen_cnt_next    = '0;
            gen_n_next      = job.n;
            h_next          = job.h;
            capped_next     = job.capped;
            acc_next        = '0;
        end
        else if (gen_active_reg)
        begin
            gen_first_next = 1'b0;
            gen_x_next     = gen_x_reg + 33'(h_reg);
            gen_cnt_next   = gen_cnt_reg + CW'(1);
            if (gen_last)
                gen_active_next = 1'b0;
        end

        if (tm_valid_reg)
        begin
            if (tm_add_reg)
                acc_next = acc_upd;
            if (tm_last_reg)
            begin
                busy_next                  = 1'b0;
                out_valid_next             = 1'b1;
                out_data_next.area         = tm_add_reg ? acc_upd[48:17] : acc_reg[48:17];
                out_data_next.steps_capped = capped_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            gen_active_reg <= 1'b0;
            ts_valid_reg   <= 1'b0;
            tm_valid_reg   <= 1'b0;
            acc_reg        <= '0;
            gen_cnt_reg    <= '0;
            gen_x_reg      <= '0;
        end
        else
        begin
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
            gen_active_reg <= gen_active_next;
            ts_valid_reg   <= d_valid;
            tm_valid_reg   <= ts_valid_reg;
            acc_reg        <= acc_next;
            gen_cnt_reg    <= gen_cnt_next;
            gen_x_reg      <= gen_x_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gen_first_reg <= gen_first_next;
        gen_n_reg     <= gen_n_next;
        h_reg         <= h_next;
        capped_reg    <= capped_next;
        out_data_reg  <= out_data_next;

        if (d_valid)
            fprev_reg <= d_pdf;
        ts_add_reg  <= !d_tag.first;
        ts_last_reg <= d_tag.last;
        ts_sum_reg  <= 25'(fprev_reg) + 25'(d_pdf);

        tm_add_reg  <= ts_add_reg;
        tm_last_reg <= ts_last_reg;
        tm_prod_reg <= 49'(ts_sum_reg) * 49'(h_reg);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/core/normal_pdf_trapezoid_integrator_top.sv
// ----------------------------------------------------------------------------
// normal_pdf_trapezoid_integrator_top
// trapezoid-rule area under the standard normal density over [start_x, end_x]
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             beat
//  in        input      in_valid / in_ready   start_x, end_x (signed Q8.24)
//  out       output     out_valid / out_ready area (Q1.31), steps_capped
//  cfg       input      cfg_we                step_width (Q.24 step h)
//
// an interval beat is taken while the front is idle, then the front runs the
// step count divide and hands the job to the queue
// the back runs one density sample a cycle, n+1 samples per job through
// the density pipeline and trapezoid sum, n at most 1048576
// the two-entry job queue lets the front take new beats while the back works
// and while a finished result waits on out_ready
// reset sets control, step width, accumulator, x; density table is constant rom
// ----------------------------------------------------------------------------
module normal_pdf_trapezoid_integrator_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [23:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  npti_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output npti_pkg::out_item_t out_data
);

    // front to queue
    logic           fq_valid;
    logic           fq_ready;
    npti_pkg::job_t fq_job;

    // queue to back
    logic           qb_valid;
    logic           qb_ready;
    npti_pkg::job_t qb_job;

    // step register, beat intake and step-count divider
    npti_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    // decoupling queue
    npti_jobq u_jobq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_job   (fq_job),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_job   (qb_job)
    );

    // sample walk, density pipeline, trapezoid sum, output register
    npti_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
